@@ rtl/tfn_pkg.sv @@
package tfn_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned EdgeW     = CoordW + 1;
  localparam int unsigned ProdW     = 2 * EdgeW;
  localparam int unsigned CrossW    = ProdW + 1;
  localparam int unsigned MagW      = ProdW;
  localparam int unsigned NormBit   = 29;
  localparam int unsigned AW        = NormBit + 1;
  localparam int unsigned SqW       = 2 * AW;
  localparam int unsigned SumW      = SqW + 2;
  localparam int unsigned RootW     = SumW / 2;
  localparam int unsigned RemW      = RootW + 1;
  localparam int unsigned QW        = 16;
  localparam int unsigned FracW     = QW - 1;
  localparam int unsigned DshW      = RootW + FracW;
  localparam int unsigned DivW      = DshW + 1;
  localparam int unsigned GrpW      = 11;
  localparam int unsigned NumGrp    = MagW / GrpW;
  localparam int unsigned GselW     = $clog2(NumGrp);
  localparam int unsigned BselW     = $clog2(GrpW);
  localparam int unsigned TopW      = $clog2(MagW);
  localparam int unsigned SqrtSteps = RootW;
  localparam int unsigned DivSteps  = QW;
  localparam int unsigned FrontW    = 9;

  typedef struct packed {
    logic [2:0][AW-1:0]  a;
    logic [2:0]          neg;
    logic                degen;
    logic [RemW-1:0]     rem;
    logic [RootW-1:0]    root;
    logic [SumW-1:0]     s;
  } sqrt_t;

  typedef struct packed {
    logic [2:0]           neg;
    logic                 degen;
    logic [DshW-1:0]      dsh;
    logic [2:0][DivW-1:0] r;
    logic [2:0][QW-1:0]   q;
  } div_t;

endpackage

@@ rtl/tfn_sqrt_cell.sv @@
module tfn_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  tfn_pkg::sqrt_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output tfn_pkg::sqrt_t data_o
);
  import tfn_pkg::*;

  logic            v_q;
  sqrt_t           d_q, d_d;
  logic [RemW+1:0] tmp, trial;

  assign ready_o = !v_q || ready_i;

  // one root bit per cell: bring down the next bit pair and try to subtract
  always_comb begin
    d_d   = data_i;
    tmp   = {data_i.rem, data_i.s[SumW-1 -: 2]};
    trial = {1'b0, data_i.root, 2'b01};
    d_d.s = {data_i.s[SumW-3:0], 2'b00};
    if (tmp >= trial) begin
      d_d.rem  = RemW'(tmp - trial);
      d_d.root = {data_i.root[RootW-2:0], 1'b1};
    end else begin
      d_d.rem  = RemW'(tmp);
      d_d.root = {data_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

@@ rtl/tfn_div_cell.sv @@
module tfn_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  tfn_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output tfn_pkg::div_t data_o
);
  import tfn_pkg::*;

  logic v_q;
  div_t d_q, d_d;

  assign ready_o = !v_q || ready_i;

  // one quotient bit per lane per cell, divisor walks down one place
  always_comb begin
    d_d     = data_i;
    d_d.dsh = data_i.dsh >> 1;
    for (int i = 0; i < 3; i++) begin
      if (data_i.r[i] >= DivW'(data_i.dsh)) begin
        d_d.r[i] = data_i.r[i] - DivW'(data_i.dsh);
        d_d.q[i] = {data_i.q[i][QW-2:0], 1'b1};
      end else begin
        d_d.q[i] = {data_i.q[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

@@ rtl/tfn_front.sv @@
module tfn_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [2:0][tfn_pkg::CoordW-1:0]      p0_i,
  input  logic [2:0][tfn_pkg::CoordW-1:0]      p1_i,
  input  logic [2:0][tfn_pkg::CoordW-1:0]      p2_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output tfn_pkg::sqrt_t                       data_o
);
  import tfn_pkg::*;

  function automatic logic [ProdW-1:0] smul(input logic [EdgeW-1:0] x,
                                            input logic [EdgeW-1:0] y);
    logic signed [ProdW-1:0] xs, ys;
    xs = {{EdgeW{x[EdgeW-1]}}, x};
    ys = {{EdgeW{y[EdgeW-1]}}, y};
    return ProdW'(xs * ys);
  endfunction

  logic [FrontW-1:0] v_q;
  logic [FrontW:0]   rdy;

  assign rdy[FrontW] = ready_i;
  for (genvar k = 0; k < FrontW; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign ready_o = rdy[0];
  assign valid_o = v_q[FrontW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < FrontW; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  logic [2:0][EdgeW-1:0]  e1_q, e2_q;
  logic [5:0][ProdW-1:0]  prod_q;
  logic [2:0][CrossW-1:0] c_q;
  logic [2:0][MagW-1:0]   m3_q, m4_q, m5_q;
  logic [2:0]             n3_q, n4_q, n5_q, n6_q, n7_q;
  logic [MagW-1:0]        or3_q, or4_q;
  logic [NumGrp-1:0]      grp_q;
  logic [TopW-1:0]        top_q;
  logic                   dg5_q, dg6_q, dg7_q;
  logic [2:0][AW-1:0]     a6_q, a7_q;
  logic [2:0][SqW-1:0]    sq_q;
  sqrt_t                  o_q;

  logic [GselW-1:0]       gsel;
  logic [BselW-1:0]       bsel;
  logic [GrpW-1:0]        gbits;
  logic [TopW-1:0]        top_d;
  logic [2:0][AW-1:0]     a_d;
  logic [MagW-1:0]        or_d;
  logic [2:0][MagW-1:0]   m_d;
  logic [2:0]             n_d;

  // magnitudes of the cross product
  always_comb begin
    or_d = '0;
    for (int i = 0; i < 3; i++) begin
      n_d[i] = c_q[i][CrossW-1];
      m_d[i] = n_d[i] ? MagW'(-c_q[i]) : MagW'(c_q[i]);
      or_d   = or_d | m_d[i];
    end
  end

  // leading one: highest nonzero group, then highest bit inside it
  always_comb begin
    gsel = '0;
    for (int g = 0; g < NumGrp; g++) begin
      if (grp_q[g]) gsel = GselW'(g);
    end
    gbits = or4_q[gsel*GrpW +: GrpW];
    bsel  = '0;
    for (int b = 0; b < GrpW; b++) begin
      if (gbits[b]) bsel = BselW'(b);
    end
    top_d = TopW'(int'(gsel) * GrpW + int'(bsel));
  end

  // align the leading one of the largest axis to the normalization bit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (top_q > TopW'(NormBit)) begin
        a_d[i] = AW'(m5_q[i] >> (top_q - TopW'(NormBit)));
      end else begin
        a_d[i] = m5_q[i][AW-1:0] << (TopW'(NormBit) - top_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= {p1_i[i][CoordW-1], p1_i[i]} - {p0_i[i][CoordW-1], p0_i[i]};
        e2_q[i] <= {p2_i[i][CoordW-1], p2_i[i]} - {p0_i[i][CoordW-1], p0_i[i]};
      end
    end
    if (rdy[1]) begin
      prod_q[0] <= smul(e1_q[1], e2_q[2]);
      prod_q[1] <= smul(e1_q[2], e2_q[1]);
      prod_q[2] <= smul(e1_q[2], e2_q[0]);
      prod_q[3] <= smul(e1_q[0], e2_q[2]);
      prod_q[4] <= smul(e1_q[0], e2_q[1]);
      prod_q[5] <= smul(e1_q[1], e2_q[0]);
    end
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= {prod_q[2*i][ProdW-1], prod_q[2*i]}
                - {prod_q[2*i+1][ProdW-1], prod_q[2*i+1]};
      end
    end
    if (rdy[3]) begin
      m3_q  <= m_d;
      n3_q  <= n_d;
      or3_q <= or_d;
    end
    if (rdy[4]) begin
      for (int g = 0; g < NumGrp; g++) begin
        grp_q[g] <= |or3_q[g*GrpW +: GrpW];
      end
      m4_q  <= m3_q;
      n4_q  <= n3_q;
      or4_q <= or3_q;
    end
    if (rdy[5]) begin
      top_q <= top_d;
      dg5_q <= (grp_q == '0);
      m5_q  <= m4_q;
      n5_q  <= n4_q;
    end
    if (rdy[6]) begin
      a6_q  <= a_d;
      n6_q  <= n5_q;
      dg6_q <= dg5_q;
    end
    if (rdy[7]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= a6_q[i] * a6_q[i];
      end
      a7_q  <= a6_q;
      n7_q  <= n6_q;
      dg7_q <= dg6_q;
    end
    if (rdy[8]) begin
      o_q.a     <= a7_q;
      o_q.neg   <= n7_q;
      o_q.degen <= dg7_q;
      o_q.rem   <= '0;
      o_q.root  <= '0;
      o_q.s     <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
    end
  end

  assign data_o = o_q;

endmodule

@@ rtl/triangle_face_normal.sv @@
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    first_*_i, second_*_i, third_*_i
// out       output     out_valid_o / out_stall_i  normal_*_o, degenerate_o
//
// One transaction enters per clock while in_stall_o is low.
// The front stages (edges, cross product, alignment, squares), 31 square-root
// cells and 16 divider cells each hold one transaction and hand it on each cycle unless the next stage is stalled.
// A stage that holds no transaction fills even while the output is stalled.
// Reset clears every valid bit; no clearing pass.
module triangle_face_normal (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  first_x_i,
  input  logic signed [31:0]  first_y_i,
  input  logic signed [31:0]  first_z_i,
  input  logic signed [31:0]  second_x_i,
  input  logic signed [31:0]  second_y_i,
  input  logic signed [31:0]  second_z_i,
  input  logic signed [31:0]  third_x_i,
  input  logic signed [31:0]  third_y_i,
  input  logic signed [31:0]  third_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  normal_x_o,
  output logic signed [15:0]  normal_y_o,
  output logic signed [15:0]  normal_z_o,
  output logic                degenerate_o
);
  import tfn_pkg::*;

  logic                  fr_ready;
  logic [SqrtSteps:0]    sv;
  logic [SqrtSteps:0]    sr;
  sqrt_t                 sd [SqrtSteps+1];
  logic [DivSteps:0]     dv;
  logic [DivSteps:0]     dr;
  div_t                  dd [DivSteps+1];

  logic                  ini_v_q;
  div_t                  ini_q, ini_d;
  logic                  out_v_q, out_rdy;
  logic [2:0][QW-1:0]    nrm_q, nrm_d;
  logic                  dgn_q;

  tfn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (fr_ready),
    .p0_i    ({first_z_i, first_y_i, first_x_i}),
    .p1_i    ({second_z_i, second_y_i, second_x_i}),
    .p2_i    ({third_z_i, third_y_i, third_x_i}),
    .valid_o (sv[0]),
    .ready_i (sr[0]),
    .data_o  (sd[0])
  );
  assign in_stall_o = !fr_ready;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[k]),
      .ready_o (sr[k]),
      .data_i  (sd[k]),
      .valid_o (sv[k+1]),
      .ready_i (sr[k+1]),
      .data_o  (sd[k+1])
    );
  end

  // divider setup: numerator a * 2^15 + L/2, divisor L aligned to the top quotient bit
  assign sr[SqrtSteps] = !ini_v_q || dr[0];
  always_comb begin
    ini_d.neg   = sd[SqrtSteps].neg;
    ini_d.degen = sd[SqrtSteps].degen;
    ini_d.dsh   = {sd[SqrtSteps].root, {FracW{1'b0}}};
    for (int i = 0; i < 3; i++) begin
      ini_d.r[i] = DivW'({sd[SqrtSteps].a[i], {FracW{1'b0}}})
                 + DivW'(sd[SqrtSteps].root >> 1);
      ini_d.q[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ini_v_q <= 1'b0;
    end else if (sr[SqrtSteps]) begin
      ini_v_q <= sv[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sr[SqrtSteps]) begin
      ini_q <= ini_d;
    end
  end

  assign dv[0] = ini_v_q;
  assign dd[0] = ini_q;

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    tfn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[k]),
      .ready_o (dr[k]),
      .data_i  (dd[k]),
      .valid_o (dv[k+1]),
      .ready_i (dr[k+1]),
      .data_o  (dd[k+1])
    );
  end

  // sign and saturate; a degenerate triangle drops to zero
  assign out_rdy      = !out_v_q || !out_stall_i;
  assign dr[DivSteps] = out_rdy;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dd[DivSteps].degen) begin
        nrm_d[i] = '0;
      end else if (dd[DivSteps].neg[i]) begin
        nrm_d[i] = -dd[DivSteps].q[i];
      end else if (dd[DivSteps].q[i][QW-1]) begin
        nrm_d[i] = {1'b0, {(QW-1){1'b1}}};
      end else begin
        nrm_d[i] = dd[DivSteps].q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= dv[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      nrm_q <= nrm_d;
      dgn_q <= dd[DivSteps].degen;
    end
  end

  assign out_valid_o  = out_v_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign degenerate_o = dgn_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result with nonzero normal");

  a_normal_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |->
      normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0)
    else $error("zero normal on non-degenerate result");

  a_no_stall_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  // Exact face normal of one triangle, Q1.15 per axis.
  function automatic normal_t face_normal(input logic signed [31:0] v [9]);
    logic signed [32:0]  e1 [3];
    logic signed [32:0]  e2 [3];
    logic signed [67:0]  cr [3];
    logic        [67:0]  mg [3];
    logic        [67:0]  all_bits;
    logic        [63:0]  a [3];
    logic        [63:0]  sum, root, rem, trial, bitv, q;
    logic        [15:0]  res [3];
    int                  top;
    normal_t             n;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 33'(v[3+i]) - 33'(v[i]);
      e2[i] = 33'(v[6+i]) - 33'(v[i]);
    end
    cr[0] = 68'(e1[1]) * 68'(e2[2]) - 68'(e1[2]) * 68'(e2[1]);
    cr[1] = 68'(e1[2]) * 68'(e2[0]) - 68'(e1[0]) * 68'(e2[2]);
    cr[2] = 68'(e1[0]) * 68'(e2[1]) - 68'(e1[1]) * 68'(e2[0]);
    all_bits = '0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i][67] ? -cr[i] : cr[i];
      all_bits |= mg[i];
    end
    top = -1;
    for (int b = 0; b < 68; b++) if (all_bits[b]) top = b;
    if (top < 0) begin
      n.nx = '0; n.ny = '0; n.nz = '0; n.degen = 1'b1;
      return n;
    end
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (top > 29) ? 64'(mg[i] >> (top - 29)) : 64'(mg[i] << (29 - top));
      sum += a[i] * a[i];
    end
    // Bitwise integer square root.
    root = '0; rem = sum; bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      trial = root + bitv;
      if (rem >= trial) begin
        rem -= trial;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (root == 0) root = 1;
    for (int i = 0; i < 3; i++) begin
      q = (a[i] * 64'd32768 + root / 2) / root;
      if (q > 64'd32768) q = 64'd32768;
      if (cr[i][67]) res[i] = 16'(-q);
      else res[i] = (q >= 64'd32768) ? 16'd32767 : 16'(q);
    end
    n.nx = res[0]; n.ny = res[1]; n.nz = res[2]; n.degen = 1'b0;
    return n;
  endfunction

  class normal_scoreboard;
    normal_t pending_normals[$];
    int      mismatches = 0;

    function void note_triangle(input logic signed [31:0] v [9]);
      pending_normals.insert(pending_normals.size(), face_normal(v));
    endfunction

    function void check_normal(input normal_t got);
      normal_t exp_n;
      if (pending_normals.size() == 0) begin
        $error("normal with no triangle pending");
        mismatches++;
        return;
      end
      exp_n = pending_normals.pop_front();
      if (got.nx !== exp_n.nx) begin
        $error("normal_x expected %0d actual %0d", exp_n.nx, got.nx); mismatches++;
      end
      if (got.ny !== exp_n.ny) begin
        $error("normal_y expected %0d actual %0d", exp_n.ny, got.ny); mismatches++;
      end
      if (got.nz !== exp_n.nz) begin
        $error("normal_z expected %0d actual %0d", exp_n.nz, got.nz); mismatches++;
      end
      if (got.degen !== exp_n.degen) begin
        $error("degenerate expected %0d actual %0d", exp_n.degen, got.degen); mismatches++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [31:0] corner [9];
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;
  bit   quiet_mode;
  bit   done_feeding;
  longint cycle_count;
  normal_scoreboard sb;

  triangle_face_normal i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .first_x_i(corner[0]), .first_y_i(corner[1]), .first_z_i(corner[2]),
    .second_x_i(corner[3]), .second_y_i(corner[4]), .second_z_i(corner[5]),
    .third_x_i(corner[6]), .third_y_i(corner[7]), .third_z_i(corner[8]),
    .out_valid_o, .out_stall_i, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // Drive one transaction and hold it until accepted.
  task automatic send_triangle(input logic signed [31:0] v [9]);
    while (!quiet_mode && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 9; i++) corner[i] <= v[i];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_triangle(v);
  endtask

  task automatic send_random();
    logic signed [31:0] v [9];
    int shape;
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) v[i] = pick_coord();
    if (shape == 0) for (int i = 0; i < 3; i++) v[3+i] = v[i];
    if (shape == 1) for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
    if (shape == 2) for (int i = 0; i < 3; i++) v[6+i] = v[i] + 2 * (v[3+i] - v[i]);
    send_triangle(v);
  endtask

  initial begin
    logic signed [31:0] v [9];
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    quiet_mode = 1'b0;
    done_feeding = 1'b0;
    for (int i = 0; i < 9; i++) corner[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: unit axes, extremes, degenerate cases, then random corners.
    for (int k = 0; k < 20; k++) begin
      for (int i = 0; i < 9; i++) v[i] = '0;
      case (k)
        0: begin v[3] = 32'h1_0000; v[7] = 32'h1_0000; end
        1: begin v[4] = 32'h1_0000; v[8] = 32'h1_0000; end
        2: begin v[5] = 32'h1_0000; v[6] = 32'h1_0000; end
        3: begin v[4] = 32'h1_0000; v[6] = 32'h1_0000; end
        4: ;
        5: begin v[3] = 32'h1_0000; v[6] = 32'h2_0000; end
        6: for (int i = 0; i < 9; i++) v[i] = 32'h8000_0000;
        7: for (int i = 0; i < 9; i++) v[i] = (i < 3) ? 32'h8000_0000 : 32'h7fff_ffff;
        8: begin
          for (int i = 0; i < 3; i++) v[i] = 32'h8000_0000;
          v[3] = 32'h7fff_ffff; v[7] = 32'h7fff_ffff;
        end
        9: begin
          for (int i = 0; i < 3; i++) v[i] = 32'h7fff_ffff;
          v[3] = 32'h8000_0000; v[7] = 32'h8000_0000; v[5] = 32'h8000_0000;
        end
        10: begin v[3] = 1; v[7] = 1; end
        11: begin v[3] = 1; v[4] = 1; v[6] = 1; v[7] = 2; v[8] = 3; end
        default: for (int i = 0; i < 9; i++) v[i] = pick_coord();
      endcase
      send_triangle(v);
    end
    for (int n = 0; n < 1800; n++) begin
      quiet_mode = (n >= 600 && n < 800);
      if (n == 900) begin
        // Hold off until the pipeline drains.
        in_valid_i <= 1'b0;
        while (sb.pending_normals.size() != 0) @(posedge clk_i);
      end
      send_random();
    end
    in_valid_i <= 1'b0;
    done_feeding = 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_normal('{normal_x_o, normal_y_o, normal_z_o, degenerate_o});
      out_stall_i <= !quiet_mode && ($urandom_range(0, 99) < 26);
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("Mismatches found");
        $finish;
      end
      if (done_feeding && sb.pending_normals.size() == 0) begin
        repeat (80) @(posedge clk_i);
        if (sb.mismatches == 0 && sb.pending_normals.size() == 0)
          $display("No mismatches found");
        else
          $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
